/* rtl/core/ypd_pkg.sv */
// shared types, constants and helpers for the yaw/pitch direction converter
package ypd_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int CW               = 34;
  localparam int AW               = 26;

  localparam logic signed [17:0] FULL_TURN    = 18'sd46080;
  localparam logic signed [17:0] HALF_TURN    = 18'sd23040;
  localparam logic signed [17:0] QUARTER_TURN = 18'sd11520;
  localparam logic signed [31:0] GAIN_Q30     = 32'sd652032875;
  localparam logic signed [16:0] DIR_MAX      = 17'sd16384;

  typedef logic signed [CW-1:0] cx_t;
  typedef logic signed [AW-1:0] ang_t;

  typedef struct packed {
    ang_t z;
    logic flip;
  } rot_in_t;

  function automatic ang_t atan_at(input int i);
    ang_t t;
    case (i)
      0:  t = 26'sd1474560;
      1:  t = 26'sd870484;
      2:  t = 26'sd459940;
      3:  t = 26'sd233473;
      4:  t = 26'sd117189;
      5:  t = 26'sd58652;
      6:  t = 26'sd29333;
      7:  t = 26'sd14667;
      8:  t = 26'sd7334;
      9:  t = 26'sd3667;
      10: t = 26'sd1833;
      11: t = 26'sd917;
      12: t = 26'sd458;
      13: t = 26'sd229;
      14: t = 26'sd115;
      15: t = 26'sd57;
      16: t = 26'sd29;
      17: t = 26'sd14;
      18: t = 26'sd7;
      19: t = 26'sd4;
      20: t = 26'sd2;
      21: t = 26'sd1;
      default: t = 26'sd0;
    endcase
    return t;
  endfunction

  // round half away from zero after an arithmetic right shift
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                     input int s);
    logic signed [63:0] half;
    half = 64'sd1 <<< s;
    half = half >>> 1;
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  function automatic logic signed [15:0] dir_clamp(input logic signed [63:0] v);
    if (v > 64'(DIR_MAX)) return 16'(DIR_MAX);
    if (v < -64'(DIR_MAX)) return -16'(DIR_MAX);
    return v[15:0];
  endfunction

  // fold an angle into [-90, 90] degrees and scale to internal units
  function automatic rot_in_t rot_prep(input logic signed [16:0] a);
    logic signed [17:0] r;
    rot_in_t o;
    r = 18'(a);
    o.flip = 1'b0;
    if (r >= FULL_TURN) r = r - FULL_TURN;
    else if (r <= -FULL_TURN) r = r + FULL_TURN;
    if (r >= HALF_TURN) r = r - FULL_TURN;
    if (r < -HALF_TURN) r = r + FULL_TURN;
    if (r > QUARTER_TURN) begin
      r = r - HALF_TURN;
      o.flip = 1'b1;
    end else if (r < -QUARTER_TURN) begin
      r = r + HALF_TURN;
      o.flip = 1'b1;
    end
    o.z = AW'(r) <<< 8;
    return o;
  endfunction

endpackage

/* rtl/core/ypd_cell.sv */
// one cordic micro-rotation step with its pipeline register
module ypd_cell #(
  parameter int STEP = 0,
  parameter bit ROT  = 1'b1,
  parameter int SW   = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  ypd_pkg::cx_t    x_in,
  input  ypd_pkg::cx_t    y_in,
  input  ypd_pkg::ang_t   z_in,
  input  logic [SW-1:0]   side_in,
  output logic            out_valid,
  output ypd_pkg::cx_t    x,
  output ypd_pkg::cx_t    y,
  output ypd_pkg::ang_t   z,
  output logic [SW-1:0]   side
);
  import ypd_pkg::*;

  cx_t  dx, dy;
  logic pos;

  assign dx  = y_in >>> STEP;
  assign dy  = x_in >>> STEP;
  // rotation drives z to zero, vectoring drives y to zero
  assign pos = ROT ? (z_in >= 0) : !(y_in > 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side <= side_in;
      if (pos) begin
        x <= x_in - dx;
        y <= y_in + dy;
        z <= z_in - atan_at(STEP);
      end else begin
        x <= x_in + dx;
        y <= y_in - dy;
        z <= z_in + atan_at(STEP);
      end
    end
  end
endmodule

/* rtl/core/ypd_chain.sv */
// row of cordic cells, one step per cell
module ypd_chain #(
  parameter int STEPS = 16,
  parameter bit ROT   = 1'b1,
  parameter int SW    = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  ypd_pkg::cx_t    x_in,
  input  ypd_pkg::cx_t    y_in,
  input  ypd_pkg::ang_t   z_in,
  input  logic [SW-1:0]   side_in,
  output logic            out_valid,
  output ypd_pkg::cx_t    x,
  output ypd_pkg::cx_t    y,
  output ypd_pkg::ang_t   z,
  output logic [SW-1:0]   side
);
  import ypd_pkg::*;

  logic          v_s [STEPS+1];
  cx_t           x_s [STEPS+1];
  cx_t           y_s [STEPS+1];
  ang_t          z_s [STEPS+1];
  logic [SW-1:0] s_s [STEPS+1];

  assign v_s[0] = in_valid;
  assign x_s[0] = x_in;
  assign y_s[0] = y_in;
  assign z_s[0] = z_in;
  assign s_s[0] = side_in;

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    ypd_cell #(.STEP(i), .ROT(ROT), .SW(SW)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(v_s[i]), .x_in(x_s[i]), .y_in(y_s[i]), .z_in(z_s[i]), .side_in(s_s[i]),
      .out_valid(v_s[i+1]), .x(x_s[i+1]), .y(y_s[i+1]), .z(z_s[i+1]), .side(s_s[i+1])
    );
  end

  assign out_valid = v_s[STEPS];
  assign x         = x_s[STEPS];
  assign y         = y_s[STEPS];
  assign z         = z_s[STEPS];
  assign side      = s_s[STEPS];
endmodule

/* rtl/core/yaw_pitch_direction_converter.sv */
// top level: angle/vector conversion over four cordic cell rows
//
// channel | signals                                         | dir
// --------+-------------------------------------------------+----
// in      | in_valid in_ready kind yaw_in pitch_in vec_x/y/z | sink
// out     | out_valid out_ready yaw_out pitch_out dir_x/y/z  | src
//
// one beat per cycle sustained unless the output stalls; pipeline stages
// are input reg, yaw vectoring row, gain multiply, pitch vectoring row,
// angle select, two parallel rotation rows, product reg, output reg
// the whole pipe advances together; a stalled output beat freezes it
// synchronous reset clears the valid bits only
module yaw_pitch_direction_converter #(
  parameter int CORDIC_STEPS = ypd_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic signed [16:0] yaw_in,
  input  logic signed [14:0] pitch_in,
  input  logic signed [23:0] vec_x,
  input  logic signed [23:0] vec_y,
  input  logic signed [23:0] vec_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] yaw_out,
  output logic signed [14:0] pitch_out,
  output logic signed [15:0] dir_x,
  output logic signed [15:0] dir_y,
  output logic signed [15:0] dir_z
);
  import ypd_pkg::*;

  localparam int SW1 = 59;
  localparam int SW2 = 35;
  localparam int SW3 = 33;

  // global advance: pipe moves unless the output beat is stuck
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // input register
  logic               s0_valid;
  logic               s0_kind;
  logic signed [16:0] s0_yaw;
  logic signed [14:0] s0_pitch;
  logic signed [23:0] s0_x, s0_y, s0_z;

  always_ff @(posedge clk) begin
    if (rst) s0_valid <= 1'b0;
    else if (en) s0_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_kind  <= kind;
      s0_yaw   <= yaw_in;
      s0_pitch <= pitch_in;
      s0_x     <= vec_x;
      s0_y     <= vec_y;
      s0_z     <= vec_z;
    end
  end

  // yaw vectoring: mirror into the right half plane, remember the half turn
  logic  vert, zneg;
  cx_t   u0, v0, xs, zs;
  assign vert = (s0_x == 24'sd0) && (s0_z == 24'sd0);
  assign zneg = s0_z < 0;
  assign xs   = CW'(s0_x) <<< 6;
  assign zs   = CW'(s0_z) <<< 6;
  assign u0   = zneg ? -zs : zs;
  assign v0   = zneg ? xs : -xs;

  logic           c1_valid;
  cx_t            c1_x, c1_y;
  ang_t           c1_z;
  logic [SW1-1:0] c1_side;

  ypd_chain #(.STEPS(CORDIC_STEPS), .ROT(1'b0), .SW(SW1)) u_yaw_vec (
    .clk(clk), .rst(rst), .en(en), .in_valid(s0_valid),
    .x_in(u0), .y_in(v0), .z_in('0),
    .side_in({s0_kind, vert, s0_pitch, s0_yaw, s0_y, zneg}),
    .out_valid(c1_valid), .x(c1_x), .y(c1_y), .z(c1_z), .side(c1_side)
  );

  logic               c1_kind, c1_vert, c1_base;
  logic signed [14:0] c1_pitch;
  logic signed [16:0] c1_yaw;
  logic signed [23:0] c1_vy;
  assign {c1_kind, c1_vert, c1_pitch, c1_yaw, c1_vy, c1_base} = c1_side;

  // wrap the vectoring angle into one full turn
  logic signed [63:0] yaw_rnd;
  logic signed [17:0] yaw_w;
  logic signed [16:0] yaw_sel;
  always_comb begin
    yaw_rnd = round_shift(64'(c1_z), 8);
    yaw_w   = 18'(yaw_rnd) + (c1_base ? HALF_TURN : 18'sd0);
    if (yaw_w < 0) yaw_w = yaw_w + FULL_TURN;
    else if (yaw_w >= FULL_TURN) yaw_w = yaw_w - FULL_TURN;
    yaw_sel = (c1_kind && !c1_vert) ? yaw_w[16:0] : c1_yaw;
  end

  // radius gain multiply stage; c1_y is the residual and is dropped
  logic               m1_valid;
  logic signed [63:0] m1_prod;
  logic               m1_kind, m1_vert, m1_vypos;
  logic signed [14:0] m1_pitch;
  logic signed [16:0] m1_yaw;
  cx_t                m1_vy;
  logic               unused_res;
  assign unused_res = ^c1_y;

  always_ff @(posedge clk) begin
    if (rst) m1_valid <= 1'b0;
    else if (en) m1_valid <= c1_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_prod  <= 64'(c1_x[31:0]) * 64'(GAIN_Q30);
      m1_kind  <= c1_kind;
      m1_vert  <= c1_vert;
      m1_vypos <= c1_vy > 0;
      m1_pitch <= c1_pitch;
      m1_yaw   <= yaw_sel;
      m1_vy    <= -(CW'(c1_vy) <<< 6);
    end
  end

  // pitch vectoring on (horizontal leg, -y)
  cx_t r0;
  logic signed [63:0] r_full;
  assign r_full = round_shift(m1_prod, 30);
  assign r0     = r_full[CW-1:0];

  logic           c2_valid;
  cx_t            c2_x, c2_y;
  ang_t           c2_z;
  logic [SW2-1:0] c2_side;

  ypd_chain #(.STEPS(CORDIC_STEPS), .ROT(1'b0), .SW(SW2)) u_pitch_vec (
    .clk(clk), .rst(rst), .en(en), .in_valid(m1_valid),
    .x_in(r0), .y_in(m1_vy), .z_in('0),
    .side_in({m1_kind, m1_vert, m1_vypos, m1_pitch, m1_yaw}),
    .out_valid(c2_valid), .x(c2_x), .y(c2_y), .z(c2_z), .side(c2_side)
  );

  logic               c2_kind, c2_vert, c2_vypos;
  logic signed [14:0] c2_pitch;
  logic signed [16:0] c2_yaw;
  assign {c2_kind, c2_vert, c2_vypos, c2_pitch, c2_yaw} = c2_side;
  logic unused_leg;
  assign unused_leg = ^{c2_x, c2_y, unused_res};

  // final pitch select: given, vertical, or clamped vectoring angle
  logic signed [63:0] p_rnd;
  logic signed [14:0] pitch_sel;
  always_comb begin
    p_rnd = round_shift(64'(c2_z), 8);
    if (!c2_kind) pitch_sel = c2_pitch;
    else if (c2_vert) pitch_sel = c2_vypos ? -15'(QUARTER_TURN) : 15'(QUARTER_TURN);
    else if (p_rnd > 64'(QUARTER_TURN)) pitch_sel = 15'(QUARTER_TURN);
    else if (p_rnd < -64'(QUARTER_TURN)) pitch_sel = -15'(QUARTER_TURN);
    else pitch_sel = p_rnd[14:0];
  end

  logic               p_valid;
  logic signed [16:0] p_yaw;
  logic signed [14:0] p_pitch;

  always_ff @(posedge clk) begin
    if (rst) p_valid <= 1'b0;
    else if (en) p_valid <= c2_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_yaw   <= c2_yaw;
      p_pitch <= pitch_sel;
    end
  end

  // sine and cosine of both angles in parallel rows
  rot_in_t ry, rp;
  assign ry = rot_prep(p_yaw);
  assign rp = rot_prep(17'(p_pitch));

  logic           c3_valid, c4_valid;
  cx_t            cy_raw, sy_raw, cp_raw, sp_raw;
  ang_t           c3_z, c4_z;
  logic [SW3-1:0] c3_side;
  logic           c4_flip;

  ypd_chain #(.STEPS(CORDIC_STEPS), .ROT(1'b1), .SW(SW3)) u_yaw_rot (
    .clk(clk), .rst(rst), .en(en), .in_valid(p_valid),
    .x_in(CW'(GAIN_Q30)), .y_in('0), .z_in(ry.z),
    .side_in({ry.flip, p_pitch, p_yaw}),
    .out_valid(c3_valid), .x(cy_raw), .y(sy_raw), .z(c3_z), .side(c3_side)
  );

  ypd_chain #(.STEPS(CORDIC_STEPS), .ROT(1'b1), .SW(1)) u_pitch_rot (
    .clk(clk), .rst(rst), .en(en), .in_valid(p_valid),
    .x_in(CW'(GAIN_Q30)), .y_in('0), .z_in(rp.z),
    .side_in(rp.flip),
    .out_valid(c4_valid), .x(cp_raw), .y(sp_raw), .z(c4_z), .side(c4_flip)
  );

  logic               c3_flip;
  logic signed [14:0] c3_pitch;
  logic signed [16:0] c3_yaw;
  assign {c3_flip, c3_pitch, c3_yaw} = c3_side;
  logic unused_z;
  assign unused_z = ^{c3_z, c4_z, unused_leg};

  // undo the half-turn fold
  cx_t cy, sy, cp, sp;
  assign cy = c3_flip ? -cy_raw : cy_raw;
  assign sy = c3_flip ? -sy_raw : sy_raw;
  assign cp = c4_flip ? -cp_raw : cp_raw;
  assign sp = c4_flip ? -sp_raw : sp_raw;

  // product stage, signed q30 by q30
  logic               q_valid;
  logic signed [63:0] q_xs, q_zc;
  cx_t                q_sp;
  logic signed [16:0] q_yaw;
  logic signed [14:0] q_pitch;

  always_ff @(posedge clk) begin
    if (rst) q_valid <= 1'b0;
    else if (en) q_valid <= c3_valid && c4_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_xs    <= 64'($signed(cp[31:0])) * 64'($signed(sy[31:0]));
      q_zc    <= 64'($signed(cp[31:0])) * 64'($signed(cy[31:0]));
      q_sp    <= sp;
      q_yaw   <= c3_yaw;
      q_pitch <= c3_pitch;
    end
  end

  // output register: round to q1.14 and clamp
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= q_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yaw_out   <= q_yaw;
      pitch_out <= q_pitch;
      dir_x     <= dir_clamp(-round_shift(q_xs, 46));
      dir_y     <= dir_clamp(-round_shift(64'(q_sp), 16));
      dir_z     <= dir_clamp(round_shift(q_zc, 46));
    end
  end
endmodule

/* rtl/core/ypd_checker.sv */
// port-level checks for the converter, bound to the top level
module ypd_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [16:0] yaw_out,
  input logic signed [14:0] pitch_out,
  input logic signed [15:0] dir_x,
  input logic signed [15:0] dir_y,
  input logic signed [15:0] dir_z
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(dir_x) && $stable(yaw_out))
    else $error("output beat dropped or changed while stalled");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stuck");

  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> dir_x >= -16'sd16384 && dir_x <= 16'sd16384 &&
                  dir_y >= -16'sd16384 && dir_y <= 16'sd16384 &&
                  dir_z >= -16'sd16384 && dir_z <= 16'sd16384)
    else $error("direction component out of range");

  a_vert_y: assert property (@(posedge clk) disable iff (rst)
    out_valid && pitch_out == 15'sd11520 |-> dir_y <= 16'sd0)
    else $error("straight-up pitch gave upward-positive y");
endmodule

bind yaw_pitch_direction_converter ypd_checker u_ypd_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .yaw_out(yaw_out), .pitch_out(pitch_out),
  .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z)
);
